/* hdl/ita_pkg.sv */
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and helpers of the integer to ascii formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  // conversion codes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_PTR  = 2'd3;

  // digit register geometry: enough decimal digits for a 64-bit magnitude
  localparam int unsigned NumDigits = 20;
  localparam int unsigned DigW      = 4 * NumDigits;
  localparam int unsigned NdigW     = $clog2(NumDigits + 1);

  // ascii characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_X     = 8'h78;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        is_long;
    logic        zero_fill;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_DABBLE,
    CMD_SHIFT
  } digit_cmd_e;

  // one digit value to its lower-case ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_LOW_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* hdl/ita_digit_sreg.sv */
// ----------------------------------------------------------------------------
// ita_digit_sreg
// Digit shift register: bit-serial binary to bcd conversion (shift and add 3)
// and digit-wise shifting toward the top for stripping and emitting.
// ----------------------------------------------------------------------------
module ita_digit_sreg
  import ita_pkg::*;
(
  input  logic            clk_i,
  input  digit_cmd_e      cmd_i,
  input  logic [DigW-1:0] load_i,
  input  logic            bit_i,
  output logic [3:0]      top_o
);

  logic [DigW-1:0] dig_q, dig_d;
  logic [DigW-1:0] adj;

  // add 3 to every digit of five or more, each digit on its own
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  // command decode
  always_comb begin
    unique case (cmd_i)
      CMD_HOLD:   dig_d = dig_q;
      CMD_LOAD:   dig_d = load_i;
      CMD_DABBLE: dig_d = {adj[DigW-2:0], bit_i};
      CMD_SHIFT:  dig_d = {dig_q[DigW-5:0], 4'b0};
      default:    dig_d = dig_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign top_o = dig_q[DigW-1 -: 4];

endmodule

/* hdl/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer conversion (signed/unsigned decimal, hex, pointer) and
// sends its ascii characters one per transfer, the final one marked last.
// ----------------------------------------------------------------------------
// Flow: the item is loaded; for decimal the 32 or 64 binary bits are shifted
// into the bcd register one bit per cycle, then leading zeros are stripped
// (one digit per cycle, down to one digit) and a step settles the padding,
// then one character per cycle goes through the output register while not stalled.
// Throughput: one item at a time; the next item is taken after the last
// character has entered the output register.
// Reset clears the state machine and the output valid flag.
module integer_to_ascii_formatter_unit
  import ita_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  state_e state_q, state_d;

  logic [1:0]       op_q;
  logic             neg_q;
  logic [63:0]      bin_q;
  logic [6:0]       cnt_q;
  logic [NdigW-1:0] ndig_q;
  logic [5:0]       pad_q;
  logic             zero_fill_q;
  logic [5:0]       width_q;
  logic             has_prec_q;
  logic [5:0]       prec_q;

  logic             out_valid_q;
  out_item_t        out_q;

  logic             accept;
  logic             can_emit;
  logic             strip_more;
  logic [3:0]       top_dig;
  digit_cmd_e       cmd;
  logic [DigW-1:0]  load_val;
  logic             emit;
  out_item_t        emit_item;

  // magnitude at the input
  logic [63:0]      sval;
  logic             in_neg;
  logic [63:0]      in_mag;
  logic             in_dec;

  // target digit count at the end of stripping
  logic [6:0]       tgt1;
  logic [6:0]       tgt;
  logic [6:0]       pad_w;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign can_emit = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // sign handling and 32-bit cut
  always_comb begin
    in_dec = (in_data_i.op == OP_SDEC) || (in_data_i.op == OP_UDEC);
    sval   = in_data_i.is_long ? in_data_i.value
                               : {{32{in_data_i.value[31]}}, in_data_i.value[31:0]};
    in_neg = 1'b0;
    if (in_data_i.op == OP_PTR) begin
      in_mag = in_data_i.value;
    end else if (in_data_i.op == OP_SDEC) begin
      in_neg = sval[63];
      in_mag = sval[63] ? (64'd0 - sval) : sval;
    end else begin
      in_mag = in_data_i.is_long ? in_data_i.value : {32'b0, in_data_i.value[31:0]};
    end
  end

  // hex and pointer load digits directly, decimal starts from an empty bcd register
  assign load_val = in_dec ? '0 : {{(DigW-64){1'b0}}, in_mag};

  assign strip_more = (top_dig == 4'd0) && (ndig_q > NdigW'(1));

  // padding count from precision and zero-padded width
  always_comb begin
    if (has_prec_q && ({1'b0, prec_q} > {{(7-NdigW){1'b0}}, ndig_q})) begin
      tgt1 = {1'b0, prec_q};
    end else begin
      tgt1 = {{(7-NdigW){1'b0}}, ndig_q};
    end
    if (zero_fill_q && ({1'b0, width_q} > tgt1 + {6'b0, neg_q})) begin
      tgt = {1'b0, width_q} - {6'b0, neg_q};
    end else begin
      tgt = tgt1;
    end
    pad_w = tgt - {{(7-NdigW){1'b0}}, ndig_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_dec ? ST_CONV : ST_STRIP;
        end
      end
      ST_CONV: begin
        if (cnt_q == 7'd1) state_d = ST_STRIP;
      end
      ST_STRIP: begin
        if (!strip_more) begin
          if (op_q == OP_PTR)       state_d = ST_PFX_ZERO;
          else if (neg_q)           state_d = ST_SIGN;
          else if (pad_w != 7'd0)   state_d = ST_PAD;
          else                      state_d = ST_DIGIT;
        end
      end
      ST_PFX_ZERO: begin
        if (can_emit) state_d = ST_PFX_X;
      end
      ST_PFX_X: begin
        if (can_emit) state_d = ST_DIGIT;
      end
      ST_SIGN: begin
        if (can_emit) state_d = (pad_q != 6'd0) ? ST_PAD : ST_DIGIT;
      end
      ST_PAD: begin
        if (can_emit && (pad_q == 6'd1)) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (can_emit && (ndig_q == NdigW'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: digit register command and character to send
  always_comb begin
    cmd       = CMD_HOLD;
    emit      = 1'b0;
    emit_item = '{out_char: CHAR_ZERO, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) cmd = CMD_LOAD;
      end
      ST_CONV: begin
        cmd = CMD_DABBLE;
      end
      ST_STRIP: begin
        if (strip_more) cmd = CMD_SHIFT;
      end
      ST_PFX_ZERO: begin
        emit = 1'b1;
      end
      ST_PFX_X: begin
        emit = 1'b1;
        emit_item.out_char = CHAR_X;
      end
      ST_SIGN: begin
        emit = 1'b1;
        emit_item.out_char = CHAR_MINUS;
      end
      ST_PAD: begin
        emit = 1'b1;
      end
      ST_DIGIT: begin
        emit = 1'b1;
        emit_item.out_char = digit_char(top_dig);
        emit_item.last     = (ndig_q == NdigW'(1));
        if (can_emit) cmd = CMD_SHIFT;
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
  end

  ita_digit_sreg u_digits (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .load_i (load_val),
    .bit_i  (bin_q[63]),
    .top_o  (top_dig)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (can_emit) out_valid_q <= emit;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (can_emit && emit) out_q <= emit_item;

    if (accept) begin
      op_q        <= in_data_i.op;
      neg_q       <= in_neg;
      bin_q       <= in_data_i.is_long ? in_mag : {in_mag[31:0], 32'b0};
      cnt_q       <= in_data_i.is_long ? 7'd64 : 7'd32;
      ndig_q      <= NdigW'(NumDigits);
      zero_fill_q <= in_data_i.zero_fill;
      width_q     <= in_data_i.field_width;
      has_prec_q  <= in_data_i.has_precision;
      prec_q      <= in_data_i.min_digits;
    end

    unique case (state_q)
      ST_CONV: begin
        bin_q <= {bin_q[62:0], 1'b0};
        cnt_q <= cnt_q - 7'd1;
      end
      ST_STRIP: begin
        if (strip_more) begin
          ndig_q <= ndig_q - NdigW'(1);
        end else begin
          pad_q <= (op_q == OP_PTR) ? 6'd0 : pad_w[5:0];
        end
      end
      ST_PAD: begin
        if (can_emit) pad_q <= pad_q - 6'd1;
      end
      ST_DIGIT: begin
        if (can_emit) ndig_q <= ndig_q - NdigW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
